// ===== design/spl_pkg.sv =====
// ----------------------------------------------------------------------------
// spl_pkg: shared types and constants of the sorted priority list
// Operation and status codes, per-cell compare flags and the cell load select.
// ----------------------------------------------------------------------------
package spl_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int KEY_BITS_DEF    = 32;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int CAP_W       = 7;   // capacity register
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;   // entry_count field
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 2'd0,
        FN_REMOVE = 2'd1,
        FN_SEARCH = 2'd2,
        FN_FETCH  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2
    } status_t;

    // compare result of one cell against the operation key/handle
    typedef struct packed {
        logic lt;    // occupied and key below operation key
        logic eq;    // occupied and key equal
        logic hit;   // occupied, key and handle equal
    } spl_flags_t;

    // what a cell loads at the end of an operation
    typedef enum logic [1:0] {
        SEL_HOLD  = 2'd0,
        SEL_NEW   = 2'd1,
        SEL_LEFT  = 2'd2,
        SEL_RIGHT = 2'd3
    } spl_sel_t;

endpackage

// ===== design/sorted_priority_list.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_list: bounded list kept in ascending key order
// Add, remove, search and fetch-head on a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one command per transaction: tuser is the operation
//   (add, remove, search, fetch head), tdata holds key and handle.
//   m_ channel returns one result per command: tuser is the status, tdata
//   holds the found entry, the entry count and the head after the command.
//   cfg_wr_en/cfg_wr_data write the capacity; write it only while idle.
// Command flow:
//   A command passes a compare state, in which every cell compares its
//   entry with the command key, then an execute state, in which the cells
//   shift and the result is registered. A new command is taken while the
//   previous one executes, but not during its compare.
// Reset and stall:
//   Reset empties the list and sets capacity to 64. While a result waits
//   in the output register, one more command is taken and compared; it
//   completes once the receiver takes the waiting result.
// ----------------------------------------------------------------------------
module sorted_priority_list #(
    parameter int DEPTH       = spl_pkg::DEPTH_DEF,
    parameter int KEY_BITS    = spl_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = spl_pkg::HANDLE_BITS_DEF,
    localparam int IN_W        = KEY_BITS + HANDLE_BITS,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W       = 2 * KEY_BITS + 2 * HANDLE_BITS
                                 + spl_pkg::COUNT_OUT_W + 1,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [spl_pkg::CAP_W-1:0]       cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [IN_TDATA_W-1:0]           s_tdata,   // key, handle, zero pad
    input  logic [spl_pkg::FUNC_W-1:0]      s_tuser,   // func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // found_key, found_handle, entry_count, head_valid, head_key, head_handle, pad
    output logic [OUT_TDATA_W-1:0]          m_tdata,
    output logic [spl_pkg::STATUS_W-1:0]    m_tuser    // status
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > spl_pkg::CAP_W) ? CNT_W : spl_pkg::CAP_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC
    } state_t;

    state_t                         state_reg, state_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [spl_pkg::CAP_W-1:0]      cap_reg, cap_next;
    spl_pkg::func_t                 func_reg, func_next;
    logic [KEY_BITS-1:0]            key_reg, key_next;
    logic [HANDLE_BITS-1:0]         handle_reg, handle_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]         m_tdata_reg, m_tdata_next;
    logic [spl_pkg::STATUS_W-1:0]   m_tuser_reg, m_tuser_next;

    logic                           s_accept;
    logic                           exec_go;
    logic                           full;
    logic [CMP_W-1:0]               cap_ext, depth_ext, limit;

    logic [KEY_BITS-1:0]            cell_key        [DEPTH];
    logic [HANDLE_BITS-1:0]         cell_handle     [DEPTH];
    logic [KEY_BITS-1:0]            cell_key_nxt    [DEPTH];
    logic [HANDLE_BITS-1:0]         cell_handle_nxt [DEPTH];
    spl_pkg::spl_flags_t            cell_flags      [DEPTH];
    spl_pkg::spl_sel_t              cell_sel        [DEPTH];
    logic [DEPTH-1:0]               occ, lt, eq, hit, first, first_eq, rm_shift;

    logic                           add_ok, rm_ok, fetch_ok, search_ok;
    logic [HANDLE_BITS-1:0]         search_handle;
    spl_pkg::status_t               status;
    logic [KEY_BITS-1:0]            found_key, head_key;
    logic [HANDLE_BITS-1:0]         found_handle, head_handle;
    logic                           head_valid;

    // ---------------- cell row ----------------
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [KEY_BITS-1:0]    l_key, r_key;
        logic [HANDLE_BITS-1:0] l_handle, r_handle;

        if (i == 0) begin : g_first
            assign l_key    = key_reg;
            assign l_handle = handle_reg;
        end else begin : g_mid_l
            assign l_key    = cell_key[i-1];
            assign l_handle = cell_handle[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign r_key    = cell_key[i];
            assign r_handle = cell_handle[i];
        end else begin : g_mid_r
            assign r_key    = cell_key[i+1];
            assign r_handle = cell_handle[i+1];
        end

        assign occ[i] = (count_reg > CNT_W'(i));
        assign lt[i]  = cell_flags[i].lt;
        assign eq[i]  = cell_flags[i].eq;
        assign hit[i] = cell_flags[i].hit;

        spl_cell #(
            .KEY_BITS    (KEY_BITS),
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .aclk            (aclk),
            .cmp_en          (state_reg == ST_CMP),
            .occ             (occ[i]),
            .op_key          (key_reg),
            .op_handle       (handle_reg),
            .sel             (cell_sel[i]),
            .left_key        (l_key),
            .left_handle     (l_handle),
            .right_key       (r_key),
            .right_handle    (r_handle),
            .cell_key        (cell_key[i]),
            .cell_handle     (cell_handle[i]),
            .cell_key_nxt    (cell_key_nxt[i]),
            .cell_handle_nxt (cell_handle_nxt[i]),
            .flags           (cell_flags[i])
        );
    end

    // cells from the first key/handle match onward shift left on remove
    spl_prefix #(
        .N (DEPTH)
    ) u_prefix (
        .in_bits  (hit),
        .out_bits (rm_shift)
    );

    // ---------------- operation decode ----------------
    assign cap_ext   = CMP_W'(cap_reg);
    assign depth_ext = CMP_W'(DEPTH);
    assign limit     = (cap_ext < depth_ext) ? cap_ext : depth_ext;
    assign full      = (CMP_W'(count_reg) >= limit);

    // lt is a prefix of the row, so the insert point is where it ends
    assign first    = {lt[DEPTH-2:0], 1'b1};
    assign first_eq = first & eq;

    assign exec_go   = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign add_ok    = (func_reg == spl_pkg::FN_ADD) && !full;
    assign rm_ok     = (func_reg == spl_pkg::FN_REMOVE) && (|hit);
    assign fetch_ok  = (func_reg == spl_pkg::FN_FETCH) && (count_reg != '0);
    assign search_ok = (func_reg == spl_pkg::FN_SEARCH) && (|first_eq);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_sel[i] = spl_pkg::SEL_HOLD;
            if (exec_go) begin
                if (add_ok && !lt[i]) begin
                    cell_sel[i] = first[i] ? spl_pkg::SEL_NEW : spl_pkg::SEL_LEFT;
                end else if (fetch_ok || (rm_ok && rm_shift[i])) begin
                    cell_sel[i] = spl_pkg::SEL_RIGHT;
                end
            end
        end
    end

    always_comb begin
        search_handle = '0;
        for (int i = 0; i < DEPTH; i++) begin
            search_handle = search_handle | (first_eq[i] ? cell_handle[i] : '0);
        end
    end

    always_comb begin
        status       = spl_pkg::STAT_OK;
        found_key    = '0;
        found_handle = '0;
        unique case (func_reg)
            spl_pkg::FN_ADD: begin
                if (full) begin
                    status = spl_pkg::STAT_FULL;
                end
            end
            spl_pkg::FN_REMOVE: begin
                if (!rm_ok) begin
                    status = spl_pkg::STAT_MISS;
                end
            end
            spl_pkg::FN_SEARCH: begin
                if (search_ok) begin
                    found_key    = key_reg;
                    found_handle = search_handle;
                end else begin
                    status = spl_pkg::STAT_MISS;
                end
            end
            spl_pkg::FN_FETCH: begin
                if (fetch_ok) begin
                    found_key    = cell_key[0];
                    found_handle = cell_handle[0];
                end else begin
                    status = spl_pkg::STAT_MISS;
                end
            end
        endcase
    end

    // ---------------- control ----------------
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        cap_next      = cfg_wr_en ? cfg_wr_data : cap_reg;
        func_next     = func_reg;
        key_next      = key_reg;
        handle_next   = handle_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (exec_go) begin
            if (add_ok) begin
                count_next = count_reg + CNT_W'(1);
            end else if (rm_ok || fetch_ok) begin
                count_next = count_reg - CNT_W'(1);
            end
        end

        head_valid  = (count_next != '0);
        head_key    = head_valid ? cell_key_nxt[0] : '0;
        head_handle = head_valid ? cell_handle_nxt[0] : '0;

        if (exec_go) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = status;
            m_tdata_next  = OUT_TDATA_W'({head_handle, head_key, head_valid,
                                          spl_pkg::COUNT_OUT_W'(count_next),
                                          found_handle, found_key});
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (exec_go) begin
                    state_next = s_accept ? ST_CMP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (s_accept) begin
            func_next   = spl_pkg::func_t'(s_tuser);
            key_next    = s_tdata[KEY_BITS-1:0];
            handle_next = s_tdata[IN_W-1:KEY_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            cap_reg      <= spl_pkg::CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cap_reg      <= cap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        func_reg    <= func_next;
        key_reg     <= key_next;
        handle_reg  <= handle_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE) || exec_go;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_no_accept_in_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> !s_tready)
        else $error("command taken during compare cycle");

    a_exec_result: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_go |=> m_tvalid)
        else $error("completed command left no result");

    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !exec_go |=> $stable(count_reg))
        else $error("entry count changed outside execute");

endmodule

// ===== design/spl_cell.sv =====
// ----------------------------------------------------------------------------
// spl_cell: one storage cell of the sorted list
// Holds one key/handle pair, compares it with the operation key and loads
// the new entry or a neighbor's entry when the list shifts.
// ----------------------------------------------------------------------------
module spl_cell #(
    parameter int KEY_BITS    = spl_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = spl_pkg::HANDLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   cmp_en,
    input  logic                   occ,
    input  logic [KEY_BITS-1:0]    op_key,
    input  logic [HANDLE_BITS-1:0] op_handle,
    input  spl_pkg::spl_sel_t      sel,
    input  logic [KEY_BITS-1:0]    left_key,
    input  logic [HANDLE_BITS-1:0] left_handle,
    input  logic [KEY_BITS-1:0]    right_key,
    input  logic [HANDLE_BITS-1:0] right_handle,
    output logic [KEY_BITS-1:0]    cell_key,
    output logic [HANDLE_BITS-1:0] cell_handle,
    output logic [KEY_BITS-1:0]    cell_key_nxt,
    output logic [HANDLE_BITS-1:0] cell_handle_nxt,
    output spl_pkg::spl_flags_t    flags
);

    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    spl_pkg::spl_flags_t    flags_reg, flags_next;

    always_comb begin
        unique case (sel)
            spl_pkg::SEL_HOLD: begin
                key_next    = key_reg;
                handle_next = handle_reg;
            end
            spl_pkg::SEL_NEW: begin
                key_next    = op_key;
                handle_next = op_handle;
            end
            spl_pkg::SEL_LEFT: begin
                key_next    = left_key;
                handle_next = left_handle;
            end
            spl_pkg::SEL_RIGHT: begin
                key_next    = right_key;
                handle_next = right_handle;
            end
        endcase
    end

    always_comb begin
        flags_next.lt  = occ && (key_reg < op_key);
        flags_next.eq  = occ && (key_reg == op_key);
        flags_next.hit = occ && (key_reg == op_key) && (handle_reg == op_handle);
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        handle_reg <= handle_next;
        if (cmp_en) begin
            flags_reg <= flags_next;
        end
    end

    assign cell_key        = key_reg;
    assign cell_handle     = handle_reg;
    assign cell_key_nxt    = key_next;
    assign cell_handle_nxt = handle_next;
    assign flags           = flags_reg;

endmodule

// ===== design/spl_prefix.sv =====
// ----------------------------------------------------------------------------
// spl_prefix: inclusive prefix OR across the cell row
// Log-depth parallel prefix; bit i is set when any input bit 0..i is set.
// ----------------------------------------------------------------------------
module spl_prefix #(
    parameter int N = spl_pkg::DEPTH_DEF
) (
    input  logic [N-1:0] in_bits,
    output logic [N-1:0] out_bits
);

    localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0] lvl [LEVELS+1];

    assign lvl[0] = in_bits;

    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
        localparam int DIST = 1 << l;
        for (genvar i = 0; i < N; i++) begin : g_bit
            if (i >= DIST) begin : g_or
                assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-DIST];
            end else begin : g_pass
                assign lvl[l+1][i] = lvl[l][i];
            end
        end
    end

    assign out_bits = lvl[LEVELS];

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the sorted priority list
// Drives add, remove, search and fetch commands over the s_ stream and keeps
// its own sorted list to predict each result. Every m_ transaction is checked
// field by field against the oldest prediction. Capacity is rewritten between
// phases while the block is idle, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIST_DEPTH = spl_pkg::DEPTH_DEF;
    localparam int KEY_W      = spl_pkg::KEY_BITS_DEF;
    localparam int HANDLE_W   = spl_pkg::HANDLE_BITS_DEF;
    localparam int CMD_W      = KEY_W + HANDLE_W;
    localparam int RES_W      = 2 * KEY_W + 2 * HANDLE_W + spl_pkg::COUNT_OUT_W + 1;

    typedef struct packed {
        spl_pkg::func_t      func;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } command_t;

    typedef struct packed {
        spl_pkg::status_t                status;
        logic [KEY_W-1:0]                found_key;
        logic [HANDLE_W-1:0]             found_handle;
        logic [spl_pkg::COUNT_OUT_W-1:0] entry_count;
        logic                            head_valid;
        logic [KEY_W-1:0]                head_key;
        logic [HANDLE_W-1:0]             head_handle;
    } list_result_t;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [spl_pkg::CAP_W-1:0]     cfg_wr_data = '0;
    logic                          s_tvalid    = 1'b0;
    logic                          s_tready;
    logic [CMD_W-1:0]              s_tdata     = '0;   // key, handle
    logic [spl_pkg::FUNC_W-1:0]    s_tuser     = '0;   // func
    logic                          m_tvalid;
    logic                          m_tready    = 1'b0;
    // found_key, found_handle, entry_count, head_valid, head_key, head_handle
    logic [RES_W-1:0]              m_tdata;
    logic [spl_pkg::STATUS_W-1:0]  m_tuser;            // status

    command_t     cmd_q[$];
    list_result_t expected_q[$];

    // predicted list contents
    logic [KEY_W-1:0]          list_keys[LIST_DEPTH];
    logic [HANDLE_W-1:0]       list_handles[LIST_DEPTH];
    int                        list_count   = 0;
    logic [spl_pkg::CAP_W-1:0] list_capacity = spl_pkg::CAP_RESET;

    int items_issued   = 0;
    int results_seen   = 0;
    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    sorted_priority_list u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // first position whose key is not below k
    function automatic int first_not_below(logic [KEY_W-1:0] k);
        int pos;
        pos = 0;
        while (pos < list_count && list_keys[pos] < k)
            pos++;
        return pos;
    endfunction

    function automatic void drop_entry(int pos);
        for (int i = pos; i + 1 < list_count; i++) begin
            list_keys[i]    = list_keys[i + 1];
            list_handles[i] = list_handles[i + 1];
        end
        list_count--;
    endfunction

    function automatic list_result_t apply_command(spl_pkg::func_t fn, logic [KEY_W-1:0] k,
                                                   logic [HANDLE_W-1:0] h);
        list_result_t r;
        int           pos;
        int           limit;
        r      = '0;
        r.status = spl_pkg::STAT_OK;
        limit  = (list_capacity < LIST_DEPTH) ? int'(list_capacity) : LIST_DEPTH;
        case (fn)
            spl_pkg::FN_ADD: begin
                if (list_count + 1 > limit) begin
                    r.status = spl_pkg::STAT_FULL;
                end else begin
                    // new entry goes in front of equal keys
                    pos = first_not_below(k);
                    for (int i = list_count; i > pos; i--) begin
                        list_keys[i]    = list_keys[i - 1];
                        list_handles[i] = list_handles[i - 1];
                    end
                    list_keys[pos]    = k;
                    list_handles[pos] = h;
                    list_count++;
                end
            end
            spl_pkg::FN_REMOVE: begin
                r.status = spl_pkg::STAT_MISS;
                pos = first_not_below(k);
                while (pos < list_count && list_keys[pos] == k) begin
                    if (list_handles[pos] == h) begin
                        drop_entry(pos);
                        r.status = spl_pkg::STAT_OK;
                        break;
                    end
                    pos++;
                end
            end
            spl_pkg::FN_SEARCH: begin
                pos = first_not_below(k);
                if (pos < list_count && list_keys[pos] == k) begin
                    r.found_key    = list_keys[pos];
                    r.found_handle = list_handles[pos];
                end else begin
                    r.status = spl_pkg::STAT_MISS;
                end
            end
            default: begin
                if (list_count == 0) begin
                    r.status = spl_pkg::STAT_MISS;
                end else begin
                    r.found_key    = list_keys[0];
                    r.found_handle = list_handles[0];
                    drop_entry(0);
                end
            end
        endcase
        r.entry_count = list_count[spl_pkg::COUNT_OUT_W-1:0];
        if (list_count > 0) begin
            r.head_valid  = 1'b1;
            r.head_key    = list_keys[0];
            r.head_handle = list_handles[0];
        end
        return r;
    endfunction

    always @(posedge aclk) begin : command_driver
        command_t next_cmd;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_command(spl_pkg::func_t'(s_tuser),
                                                   s_tdata[KEY_W-1:0],
                                                   s_tdata[CMD_W-1:KEY_W]));
            if (!s_tvalid || s_tready) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_cmd = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_cmd.handle, next_cmd.key};
                    s_tuser  <= next_cmd.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [KEY_W-1:0] want_v,
                               logic [KEY_W-1:0] got_v);
        if (got_v !== want_v) begin
            fail_count++;
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        list_result_t got;
        list_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.status       = spl_pkg::status_t'(m_tuser);
                got.found_key    = m_tdata[31:0];
                got.found_handle = m_tdata[47:32];
                got.entry_count  = m_tdata[54:48];
                got.head_valid   = m_tdata[55];
                got.head_key     = m_tdata[87:56];
                got.head_handle  = m_tdata[103:88];
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $error("result transaction with no command pending");
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", KEY_W'(want.status), KEY_W'(got.status));
                    check_field("found_key", want.found_key, got.found_key);
                    check_field("found_handle", KEY_W'(want.found_handle),
                                KEY_W'(got.found_handle));
                    check_field("entry_count", KEY_W'(want.entry_count),
                                KEY_W'(got.entry_count));
                    check_field("head_valid", KEY_W'(want.head_valid),
                                KEY_W'(got.head_valid));
                    check_field("head_key", want.head_key, got.head_key);
                    check_field("head_handle", KEY_W'(want.head_handle),
                                KEY_W'(got.head_handle));
                end
            end
        end
    end

    task automatic queue_command(spl_pkg::func_t fn, logic [KEY_W-1:0] k,
                                 logic [HANDLE_W-1:0] h);
        command_t c;
        c.func   = fn;
        c.key    = k;
        c.handle = h;
        cmd_q.push_back(c);
        items_issued++;
    endtask

    // hold until every queued command has its result back
    task automatic drain();
        while (results_seen < items_issued)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [spl_pkg::CAP_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= v;
        list_capacity = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // keys mostly from a small pool so removes and searches hit
    task automatic run_random(int n, int add_pct, int wide_pct);
        spl_pkg::func_t fn;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < add_pct) begin
                fn = spl_pkg::FN_ADD;
            end else begin
                case ($urandom_range(2))
                    0:       fn = spl_pkg::FN_REMOVE;
                    1:       fn = spl_pkg::FN_SEARCH;
                    default: fn = spl_pkg::FN_FETCH;
                endcase
            end
            queue_command(fn,
                ($urandom_range(99) < wide_pct) ? KEY_W'($urandom) : KEY_W'($urandom_range(15)),
                ($urandom_range(99) < 10) ? HANDLE_W'($urandom_range(16'hffff))
                                          : HANDLE_W'($urandom_range(3)));
        end
    endtask

    initial begin : stimulus
        int pick;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // empty list, extremes, equal keys, failed operations
        write_capacity(spl_pkg::CAP_RESET);
        queue_command(spl_pkg::FN_FETCH, '0, '0);
        queue_command(spl_pkg::FN_SEARCH, '0, '0);
        queue_command(spl_pkg::FN_REMOVE, '0, '0);
        queue_command(spl_pkg::FN_ADD, '0, '0);
        queue_command(spl_pkg::FN_ADD, '1, '1);
        queue_command(spl_pkg::FN_ADD, 32'd100, 16'd1);
        queue_command(spl_pkg::FN_ADD, 32'd100, 16'd2);
        queue_command(spl_pkg::FN_SEARCH, 32'd100, 16'd0);
        queue_command(spl_pkg::FN_REMOVE, 32'd100, 16'd1);
        queue_command(spl_pkg::FN_REMOVE, 32'd100, 16'd7);
        queue_command(spl_pkg::FN_SEARCH, 32'd55, 16'd0);
        queue_command(spl_pkg::FN_SEARCH, '1, 16'h5a5a);
        queue_command(spl_pkg::FN_FETCH, '0, '0);
        queue_command(spl_pkg::FN_FETCH, '0, '0);
        queue_command(spl_pkg::FN_FETCH, '0, '0);
        queue_command(spl_pkg::FN_FETCH, '0, '0);
        drain();

        // zero capacity refuses every add
        write_capacity('0);
        queue_command(spl_pkg::FN_ADD, 32'd3, 16'd3);
        queue_command(spl_pkg::FN_SEARCH, 32'd3, 16'd3);
        drain();

        write_capacity(spl_pkg::CAP_W'(2));
        queue_command(spl_pkg::FN_ADD, 32'd9, 16'd1);
        queue_command(spl_pkg::FN_ADD, 32'd4, 16'd2);
        queue_command(spl_pkg::FN_ADD, 32'd6, 16'd3);
        queue_command(spl_pkg::FN_FETCH, '0, '0);
        queue_command(spl_pkg::FN_FETCH, '0, '0);
        drain();

        // capacity above depth: fill up to the full depth
        write_capacity('1);
        run_random(150, 70, 10);
        drain();
        send_idle_pct = 85;
        run_random(150, 40, 10);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 85;
        write_capacity(spl_pkg::CAP_W'(64));
        run_random(150, 50, 5);
        drain();
        run_random(100, 50, 5);
        drain();

        send_idle_pct  = 22;
        recv_stall_pct = 22;
        write_capacity(spl_pkg::CAP_W'(10));
        run_random(150, 60, 10);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_capacity(spl_pkg::CAP_W'(1));
        run_random(100, 50, 10);
        drain();

        for (int p = 0; p < 2; p++) begin
            pick = $urandom_range(3);
            send_idle_pct  = (pick == 1 || pick == 3) ? 85 : 0;
            recv_stall_pct = (pick == 2) ? 85 : ((pick == 3) ? 22 : 0);
            if (pick == 3)
                send_idle_pct = 22;
            write_capacity(spl_pkg::CAP_W'($urandom_range(127)));
            run_random(125, 55, 10);
            drain();
        end

        repeat (20) @(posedge aclk);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
